FILE: hdl/kmp_pkg.sv
// kmp_pkg: shared types and constants for the KMP stream matcher.
// Holds the transaction payload structs, request codes, register index, FSM states and cell write controls.
// No dependencies.
package kmp_pkg;

    localparam int PAT_MAX_DEF = 16;

    // request codes carried in req_type
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // configuration register indexes
    localparam int REG_PATTERN_LENGTH = 0;

    typedef struct packed {
        logic       req_type;
        logic [3:0] pattern_index;
        logic [7:0] symbol;
        logic       text_start;
    } t_in_item;

    typedef struct packed {
        logic        match_found;
        logic [31:0] match_start;
        logic        load_error;
    } t_out_item;

    typedef struct packed {
        logic we_sym;
        logic we_fail;
    } t_cell_wr;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

FILE: hdl/kmp_cell.sv
// kmp_cell: one pattern position, holding its byte and its failure value.
// Passes the read chain on to its neighbor, replacing it when it is addressed.
// Depends on kmp_pkg.
module kmp_cell #(
    parameter int IW    = 4,
    parameter int LW    = 5,
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  kmp_pkg::t_cell_wr i_wr,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [7:0]        i_wr_sym,
    input  logic [LW-1:0]     i_wr_fail,
    input  logic [IW-1:0]     i_rd_addr_p,
    input  logic [IW-1:0]     i_rd_addr_f,
    input  logic [7:0]        i_sym_chain,
    input  logic [LW-1:0]     i_fail_chain,
    output logic [7:0]        o_sym_chain,
    output logic [LW-1:0]     o_fail_chain
);

    localparam logic [IW-1:0] MY_ADDR = IW'(INDEX);

    logic [7:0]    r_sym;
    logic [LW-1:0] r_fail;
    logic          wr_hit;

    assign wr_hit = (i_wr_addr == MY_ADDR);

    always_ff @(posedge i_clk) begin
        if (i_wr.we_sym && wr_hit) begin
            r_sym <= i_wr_sym;
        end
        if (i_wr.we_fail && wr_hit) begin
            r_fail <= i_wr_fail;
        end
    end

    assign o_sym_chain  = (i_rd_addr_p == MY_ADDR) ? r_sym  : i_sym_chain;
    assign o_fail_chain = (i_rd_addr_f == MY_ADDR) ? r_fail : i_fail_chain;

endmodule

FILE: hdl/kmp_cell_row.sv
// kmp_cell_row: the row of pattern cells, chained for reads.
// One write port; one byte read and one failure read per cycle along the chain.
// Depends on kmp_pkg and kmp_cell.
module kmp_cell_row #(
    parameter int PAT_MAX = kmp_pkg::PAT_MAX_DEF,
    parameter int IW      = 4,
    parameter int LW      = 5
) (
    input  logic              i_clk,
    input  kmp_pkg::t_cell_wr i_wr,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [7:0]        i_wr_sym,
    input  logic [LW-1:0]     i_wr_fail,
    input  logic [IW-1:0]     i_rd_addr_p,
    input  logic [IW-1:0]     i_rd_addr_f,
    output logic [7:0]        o_rd_sym,
    output logic [LW-1:0]     o_rd_fail
);

    logic [7:0]    sym_chain  [0:PAT_MAX];
    logic [LW-1:0] fail_chain [0:PAT_MAX];

    assign sym_chain[0]  = '0;
    assign fail_chain[0] = '0;

    for (genvar g = 0; g < PAT_MAX; g++) begin : g_cell
        kmp_cell #(
            .IW    (IW),
            .LW    (LW),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_wr         (i_wr),
            .i_wr_addr    (i_wr_addr),
            .i_wr_sym     (i_wr_sym),
            .i_wr_fail    (i_wr_fail),
            .i_rd_addr_p  (i_rd_addr_p),
            .i_rd_addr_f  (i_rd_addr_f),
            .i_sym_chain  (sym_chain[g]),
            .i_fail_chain (fail_chain[g]),
            .o_sym_chain  (sym_chain[g+1]),
            .o_fail_chain (fail_chain[g+1])
        );
    end

    assign o_rd_sym  = sym_chain[PAT_MAX];
    assign o_rd_fail = fail_chain[PAT_MAX];

endmodule

FILE: hdl/kmp_stream_matcher.sv
// KMP stream matcher, top level. One item in flight at a time.
// Pattern byte at index zero or out of order: result registered on the port in the cycle after acceptance.
// In-order pattern byte or text byte: walks the failure chain through the cell row in ST_WALK
// (one step per cycle, one extra step when the pattern length was lowered mid-text), then registers the result.
// Next item accepted as the sink takes the result, and not while a result is stalled.
// Synchronous active-low reset clears control and pattern_length (to 1); cells keep contents.
module kmp_stream_matcher #(
    parameter int PAT_MAX = kmp_pkg::PAT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kmp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kmp_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int LW = $clog2(PAT_MAX + 1);
    localparam int KW = (LW > 4) ? LW : 4;
    localparam int CW = (LW > 5) ? LW : 5;

    kmp_pkg::t_state    r_state, n_state;
    logic [4:0]         r_pat_len;
    logic [LW-1:0]      r_bpl, n_bpl;
    logic [LW-1:0]      r_nli, n_nli;
    logic [LW-1:0]      r_match_len, n_match_len;
    logic [31:0]        r_text_pos, n_text_pos;
    logic [LW-1:0]      r_j, n_j;
    logic [7:0]         r_sym, n_sym;
    logic               r_is_text, n_is_text;
    logic [IW-1:0]      r_ld_idx, n_ld_idx;
    logic               r_out_valid, n_out_valid;
    kmp_pkg::t_out_item r_out_item, n_out_item;

    kmp_pkg::t_cell_wr  wr_ctl;
    logic [IW-1:0]      wr_addr;
    logic [7:0]         wr_sym;
    logic [LW-1:0]      wr_fail;
    logic [IW-1:0]      rd_addr_p, rd_addr_f;
    logic [7:0]         rd_sym;
    logic [LW-1:0]      rd_fail;

    logic [CW-1:0]      cfg_c, m_c;
    logic [LW-1:0]      m, m_minus1, j_minus1, j_inc, fail_clamped, f_sel;
    logic               out_free, in_accept, j_over, sym_eq, cont, found;
    logic [KW-1:0]      idx_k, nli_k, bpl_k;
    logic               idx_ok;
    logic               cfg_hit;

    // effective pattern length, clamped to 1..PAT_MAX
    assign cfg_c = CW'(r_pat_len);
    assign m_c   = (cfg_c == '0) ? CW'(1) : ((cfg_c > CW'(PAT_MAX)) ? CW'(PAT_MAX) : cfg_c);
    assign m     = LW'(m_c);
    assign m_minus1 = m - LW'(1);
    assign j_minus1 = r_j - LW'(1);

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && (r_state == kmp_pkg::ST_IDLE) && out_free;
    assign o_in_stall = !((r_state == kmp_pkg::ST_IDLE) && out_free);

    // one walk step: read byte at j and either the failure of j-1 or of m-1
    assign j_over  = r_is_text && (r_j >= m);
    assign sym_eq  = (rd_sym == r_sym);
    assign cont    = !j_over && (r_j != '0) && !sym_eq;
    assign j_inc   = r_j + LW'(sym_eq);
    assign found   = r_is_text && (j_inc == m);
    assign fail_clamped = (rd_fail >= m) ? '0 : rd_fail;

    assign rd_addr_p = r_j[IW-1:0];
    assign f_sel     = cont ? j_minus1 : m_minus1;
    assign rd_addr_f = f_sel[IW-1:0];

    assign idx_k  = KW'(i_in_item.pattern_index);
    assign nli_k  = KW'(r_nli);
    assign bpl_k  = KW'(r_bpl);
    assign idx_ok = (idx_k == nli_k) && (idx_k < KW'(PAT_MAX));

    kmp_cell_row #(
        .PAT_MAX (PAT_MAX),
        .IW      (IW),
        .LW      (LW)
    ) u_row (
        .i_clk       (i_clk),
        .i_wr        (wr_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_sym    (wr_sym),
        .i_wr_fail   (wr_fail),
        .i_rd_addr_p (rd_addr_p),
        .i_rd_addr_f (rd_addr_f),
        .o_rd_sym    (rd_sym),
        .o_rd_fail   (rd_fail)
    );

    always_comb begin
        n_state     = r_state;
        n_bpl       = r_bpl;
        n_nli       = r_nli;
        n_match_len = r_match_len;
        n_text_pos  = r_text_pos;
        n_j         = r_j;
        n_sym       = r_sym;
        n_is_text   = r_is_text;
        n_ld_idx    = r_ld_idx;
        n_out_valid = (r_out_valid && i_out_stall);
        n_out_item  = r_out_item;
        wr_ctl      = '0;
        wr_addr     = r_ld_idx;
        wr_sym      = i_in_item.symbol;
        wr_fail     = j_inc;

        case (r_state)
            kmp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_item.req_type == kmp_pkg::REQ_TEXT) begin
                        n_is_text = 1'b1;
                        n_sym     = i_in_item.symbol;
                        n_state   = kmp_pkg::ST_WALK;
                        if (i_in_item.text_start) begin
                            n_j        = '0;
                            n_text_pos = '0;
                        end else begin
                            n_j = r_match_len;
                        end
                    end else if (i_in_item.pattern_index == '0) begin
                        // restart of the pattern load
                        wr_ctl.we_sym  = 1'b1;
                        wr_ctl.we_fail = 1'b1;
                        wr_addr        = '0;
                        wr_fail        = '0;
                        n_bpl          = '0;
                        n_nli          = LW'(1);
                        n_out_valid    = 1'b1;
                        n_out_item     = '0;
                    end else if (idx_ok) begin
                        wr_ctl.we_sym = 1'b1;
                        wr_addr       = IW'(i_in_item.pattern_index);
                        n_is_text     = 1'b0;
                        n_sym         = i_in_item.symbol;
                        n_ld_idx      = IW'(i_in_item.pattern_index);
                        n_j           = (bpl_k >= idx_k) ? '0 : r_bpl;
                        n_state       = kmp_pkg::ST_WALK;
                    end else begin
                        n_out_valid           = 1'b1;
                        n_out_item            = '0;
                        n_out_item.load_error = 1'b1;
                    end
                end
            end
            kmp_pkg::ST_WALK: begin
                if (j_over) begin
                    // pattern length was lowered to or below the matched length
                    n_j = fail_clamped;
                end else if (cont) begin
                    n_j = rd_fail;
                end else if (out_free) begin
                    n_state     = kmp_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_item  = '0;
                    if (r_is_text) begin
                        n_out_item.match_found = found;
                        n_out_item.match_start = found ? (r_text_pos + 32'd1 - 32'(m)) : '0;
                        n_match_len = found ? fail_clamped : j_inc;
                        n_text_pos  = r_text_pos + 32'd1;
                    end else begin
                        wr_ctl.we_fail = 1'b1;
                        n_bpl          = j_inc;
                        n_nli          = LW'(r_ld_idx) + LW'(1);
                    end
                end
            end
            default: begin
                n_state = kmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bpl       <= '0;
            r_nli       <= '0;
            r_match_len <= '0;
            r_text_pos  <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_bpl       <= n_bpl;
            r_nli       <= n_nli;
            r_match_len <= n_match_len;
            r_text_pos  <= n_text_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_sym      <= n_sym;
        r_is_text  <= n_is_text;
        r_ld_idx   <= n_ld_idx;
        r_out_item <= n_out_item;
    end

    // configuration register
    assign cfg_hit = (paddr[2] == 1'(kmp_pkg::REG_PATTERN_LENGTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= 5'd1;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_pat_len <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_hit ? {27'd0, r_pat_len} : '0;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hdl/kmp_checker.sv
// kmp_checker: port-level assertions for the KMP stream matcher, bound to the top level.
// Depends on kmp_pkg and kmp_stream_matcher.
module kmp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input kmp_pkg::t_out_item o_out_item
);

    // a result waiting on the sink stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction dropped or changed while stalled");

    // after an accepted transaction the block is busy or shows a result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall || o_out_valid)
        else $error("accepted transaction neither in work nor delivered");

    // a match and a load error never come from one item
    a_found_vs_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.match_found && o_out_item.load_error))
        else $error("match reported on a pattern load");

    // start position only carried with a match
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.match_found |-> o_out_item.match_start == 32'd0)
        else $error("match_start nonzero without a match");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
